### rtl/i2crf_pkg.sv
// shared constants, types and helpers of the i2c register file with sample ring
package i2crf_pkg;

  localparam int RING_DEPTH = 2048;
  localparam int REG_COUNT  = 32;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int RING_CW = $clog2(RING_DEPTH + 1);
  localparam int REG_AW  = $clog2(REG_COUNT);

  localparam logic [REG_AW-1:0] REG_CHANNEL_MASK = REG_AW'(8'h10);
  localparam logic [REG_AW-1:0] REG_DECIMATION   = REG_AW'(8'h11);
  localparam logic [REG_AW-1:0] REG_RING_STATUS  = REG_AW'(8'h18);
  localparam logic [REG_AW-1:0] REG_RING_DATA    = REG_AW'(8'h19);

  typedef enum logic [2:0] {
    OP_STOP  = 3'd0,
    OP_ADDR  = 3'd1,
    OP_DATA  = 3'd2,
    OP_TX    = 3'd3,
    OP_FRAME = 3'd4,
    OP_PUSH  = 3'd5
  } op_e;

  typedef struct packed {
    logic              rd_en;
    logic [REG_AW-1:0] rd_idx;
    logic              wr_en;
    logic [REG_AW-1:0] wr_idx;
    logic [15:0]       wr_data;
  } bank_req_t;

  // received byte modulo the register count
  function automatic logic [REG_AW-1:0] reg_wrap(input logic [7:0] b);
    return REG_AW'({1'b0, b} % 9'(REG_COUNT));
  endfunction

endpackage

### rtl/i2crf_if.sv
// request and result channel interfaces
interface i2crf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic        read_not_write;
  logic [7:0]  byte_in;
  logic [3:0]  channel;
  logic [15:0] sample_value;

  modport source (output valid, operation, read_not_write, byte_in, channel, sample_value,
                  input ready);
  modport sink (input valid, operation, read_not_write, byte_in, channel, sample_value,
                output ready);
endinterface

interface i2crf_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic        tx_valid;
  logic [11:0] samples_available;
  logic        overflowed;
  logic        reg_write_strobe;
  logic [4:0]  reg_write_index;
  logic [15:0] reg_write_value;
  logic        transfer_end;

  modport source (output valid, tx_byte, tx_valid, samples_available, overflowed,
                  reg_write_strobe, reg_write_index, reg_write_value, transfer_end,
                  input ready);
  modport sink (input valid, tx_byte, tx_valid, samples_available, overflowed,
                reg_write_strobe, reg_write_index, reg_write_value, transfer_end,
                output ready);
endinterface

### rtl/i2crf_regbank.sv
// register bank memory with per-entry valid bits, registered read
module i2crf_regbank (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2crf_pkg::bank_req_t  req_i,
  output logic [15:0]           rd_data_o
);

  logic [15:0]                     mem_q [i2crf_pkg::REG_COUNT];
  logic [i2crf_pkg::REG_COUNT-1:0] vld_q;
  logic [15:0]                     rd_raw_q;
  logic                            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= mem_q[req_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_idx];
      end
    end
  end

  // entries never written read as zero
  assign rd_data_o = rd_vld_q ? rd_raw_q : 16'h0000;

endmodule

### rtl/i2c_register_file_with_sample_fifo.sv
// top level: i2c target register map with decimated sample ring
// a request is registered when accepted; its result is registered when the update cycle commits
// a new request is taken only once the last one is committed: the memory read cycle of the
//   register bank and sample ring is followed by the update and write-back cycle
// a waiting result holds the block in its update cycle until it is taken
// reset: control state cleared with the pending register index valid at zero, bank entries
//   read as zero, ring contents left undefined with no clearing pass
module i2c_register_file_with_sample_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2crf_req_if.sink   req_i,
  i2crf_rsp_if.source rsp_o
);

  localparam int RING_SW = i2crf_pkg::RING_CW + 1;
  localparam int RAW     = i2crf_pkg::RING_AW;
  localparam int RCW     = i2crf_pkg::RING_CW;
  localparam int RGW     = i2crf_pkg::REG_AW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_WRITE_ADDR   = 3'd1;
  localparam logic [2:0] PH_WRITE_REG    = 3'd2;
  localparam logic [2:0] PH_READ_REG     = 3'd3;
  localparam logic [2:0] PH_READ_SAMPLES = 3'd4;

  logic state_q, state_d;
  logic accept, commit;

  logic [2:0]  op_q;
  logic        rnw_q;
  logic [7:0]  byte_q;
  logic [3:0]  ch_q;
  logic [15:0] sv_q;

  logic [2:0]     phase_q, phase_d;
  logic [RGW-1:0] pend_q, pend_d;
  logic           pend_vld_q, pend_vld_d;
  logic [RGW-1:0] wptr_q, wptr_d;
  logic           whp_q, whp_d;
  logic [7:0]     low_q, low_d;
  logic [RGW-1:0] rptr_q, rptr_d;
  logic           rhp_q, rhp_d;
  logic [7:0]     hhold_q, hhold_d;
  logic           sph_q, sph_d;
  logic [RAW-1:0] head_q, head_d;
  logic [RCW-1:0] count_q, count_d;
  logic           ovf_q, ovf_d;
  logic [15:0]    dec_q, dec_d;
  logic [15:0]    mask_q, mask_d;
  logic [15:0]    decim_q, decim_d;

  logic [15:0]    ring_q [i2crf_pkg::RING_DEPTH];
  logic [15:0]    ring_rd_q;
  logic           ring_we;
  logic [RAW-1:0] ring_wa;
  logic [RING_SW-1:0] ring_sum;

  i2crf_pkg::bank_req_t bank_req;
  logic [15:0]          bank_rd;
  logic                 bank_we;
  logic [RGW-1:0]       bank_wi;
  logic [15:0]          bank_wd;

  logic [RGW-1:0] wp, rp;
  logic           whp, rhp, sph, ovf_n;
  logic [15:0]    word;

  logic [7:0]  tx_byte_d;
  logic        tx_vld_d, strobe_d, tend_d;
  logic [4:0]  widx_d;
  logic [15:0] wval_d;

  logic        out_vld_q;
  logic [7:0]  tx_byte_q;
  logic        tx_vld_q, strobe_q, tend_q, ovf_out_q;
  logic [4:0]  widx_q;
  logic [15:0] wval_q;
  logic [11:0] avail_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == S_EXEC) && (!out_vld_q || rsp_o.ready);

  assign bank_req.rd_en   = accept;
  assign bank_req.rd_idx  = pend_vld_q ? pend_q : rptr_q;
  assign bank_req.wr_en   = commit && bank_we;
  assign bank_req.wr_idx  = bank_wi;
  assign bank_req.wr_data = bank_wd;

  i2crf_regbank u_regbank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (bank_req),
    .rd_data_o (bank_rd)
  );

  assign ring_sum = RING_SW'(head_q) + RING_SW'(count_q);
  assign ring_wa  = (ring_sum >= RING_SW'(i2crf_pkg::RING_DEPTH))
                  ? RAW'(ring_sum - RING_SW'(i2crf_pkg::RING_DEPTH)) : RAW'(ring_sum);

  always_ff @(posedge clk_i) begin
    if (commit && ring_we) begin
      ring_q[ring_wa] <= sv_q;
    end
    if (accept) begin
      ring_rd_q <= ring_q[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.operation;
      rnw_q  <= req_i.read_not_write;
      byte_q <= req_i.byte_in;
      ch_q   <= req_i.channel;
      sv_q   <= req_i.sample_value;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    wptr_d     = wptr_q;
    whp_d      = whp_q;
    low_d      = low_q;
    rptr_d     = rptr_q;
    rhp_d      = rhp_q;
    hhold_d    = hhold_q;
    sph_d      = sph_q;
    head_d     = head_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    dec_d      = dec_q;
    mask_d     = mask_q;
    decim_d    = decim_q;
    tx_byte_d  = 8'h00;
    tx_vld_d   = 1'b0;
    strobe_d   = 1'b0;
    widx_d     = 5'd0;
    wval_d     = 16'h0000;
    tend_d     = 1'b0;
    bank_we    = 1'b0;
    bank_wi    = i2crf_pkg::REG_RING_STATUS;
    bank_wd    = 16'h0000;
    ring_we    = 1'b0;
    wp         = pend_vld_q ? pend_q : wptr_q;
    whp        = pend_vld_q ? 1'b0 : whp_q;
    rp         = pend_vld_q ? pend_q : rptr_q;
    rhp        = pend_vld_q ? 1'b0 : rhp_q;
    sph        = pend_vld_q ? 1'b0 : sph_q;
    ovf_n      = ovf_q;
    word       = {byte_q, low_q};

    case (op_q)
      i2crf_pkg::OP_STOP: begin
        phase_d = PH_IDLE;
        tend_d  = 1'b1;
      end
      i2crf_pkg::OP_ADDR: begin
        tend_d = 1'b1;
        if (!rnw_q) begin
          phase_d = PH_WRITE_ADDR;
        end else if (pend_vld_q && pend_q == i2crf_pkg::REG_RING_DATA) begin
          phase_d = PH_READ_SAMPLES;
        end else begin
          phase_d = PH_READ_REG;
        end
      end
      i2crf_pkg::OP_DATA: begin
        if (phase_q == PH_WRITE_ADDR) begin
          pend_d     = i2crf_pkg::reg_wrap(byte_q);
          pend_vld_d = 1'b1;
          phase_d    = PH_WRITE_REG;
        end else if (phase_q == PH_WRITE_REG) begin
          pend_vld_d = 1'b0;
          wptr_d     = wp;
          if (!whp) begin
            low_d = byte_q;
            whp_d = 1'b1;
          end else begin
            whp_d    = 1'b0;
            bank_we  = 1'b1;
            bank_wi  = wp;
            bank_wd  = word;
            strobe_d = 1'b1;
            widx_d   = 5'(wp);
            wval_d   = word;
            if (wp == i2crf_pkg::REG_DECIMATION) begin
              dec_d   = 16'h0000;
              decim_d = word;
            end
            if (wp == i2crf_pkg::REG_CHANNEL_MASK) begin
              mask_d = word;
            end
            if (wp == i2crf_pkg::REG_RING_STATUS && word == 16'h0000) begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            wptr_d = (wp == RGW'(i2crf_pkg::REG_COUNT - 1)) ? '0 : wp + 1'b1;
          end
        end
      end
      i2crf_pkg::OP_TX: begin
        if (phase_q == PH_READ_REG) begin
          tx_vld_d   = 1'b1;
          pend_vld_d = 1'b0;
          if (!rhp) begin
            tx_byte_d = bank_rd[7:0];
            hhold_d   = bank_rd[15:8];
            rhp_d     = 1'b1;
            rptr_d    = rp;
          end else begin
            tx_byte_d = hhold_q;
            rhp_d     = 1'b0;
            rptr_d    = (rp == RGW'(i2crf_pkg::REG_COUNT - 1)) ? '0 : rp + 1'b1;
          end
        end else if (phase_q == PH_READ_SAMPLES) begin
          tx_vld_d   = 1'b1;
          pend_vld_d = 1'b0;
          if (!sph) begin
            if (count_q != '0) tx_byte_d = ring_rd_q[7:0];
            sph_d = 1'b1;
          end else begin
            if (count_q != '0) begin
              tx_byte_d = ring_rd_q[15:8];
              head_d    = (head_q == RAW'(i2crf_pkg::RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
              count_d   = count_q - 1'b1;
              if (count_q == RCW'(1)) ovf_d = 1'b0;
            end
            sph_d = 1'b0;
          end
          bank_we = 1'b1;
          bank_wd = {ovf_d, 15'(count_d)};
        end
      end
      i2crf_pkg::OP_FRAME: begin
        dec_d = (dec_q == decim_q) ? 16'h0000 : dec_q + 16'h0001;
      end
      i2crf_pkg::OP_PUSH: begin
        if (dec_q == 16'h0000 && mask_q[ch_q]) begin
          ovf_n = ovf_q || (count_q >= RCW'(i2crf_pkg::RING_DEPTH));
          ovf_d = ovf_n;
          if (!ovf_n) begin
            ring_we = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        bank_we = 1'b1;
        bank_wd = {ovf_d, 15'(count_d)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_IDLE;
      pend_q     <= '0;
      pend_vld_q <= 1'b1;
      wptr_q     <= '0;
      whp_q      <= 1'b0;
      low_q      <= 8'h00;
      rptr_q     <= '0;
      rhp_q      <= 1'b0;
      hhold_q    <= 8'h00;
      sph_q      <= 1'b0;
      head_q     <= '0;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      dec_q      <= 16'h0000;
      mask_q     <= 16'h0000;
      decim_q    <= 16'h0000;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        phase_q    <= phase_d;
        pend_q     <= pend_d;
        pend_vld_q <= pend_vld_d;
        wptr_q     <= wptr_d;
        whp_q      <= whp_d;
        low_q      <= low_d;
        rptr_q     <= rptr_d;
        rhp_q      <= rhp_d;
        hhold_q    <= hhold_d;
        sph_q      <= sph_d;
        head_q     <= head_d;
        count_q    <= count_d;
        ovf_q      <= ovf_d;
        dec_q      <= dec_d;
        mask_q     <= mask_d;
        decim_q    <= decim_d;
        out_vld_q  <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      tx_byte_q <= tx_byte_d;
      tx_vld_q  <= tx_vld_d;
      avail_q   <= 12'(count_d);
      ovf_out_q <= ovf_d;
      strobe_q  <= strobe_d;
      widx_q    <= widx_d;
      wval_q    <= wval_d;
      tend_q    <= tend_d;
    end
  end

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.tx_byte           = tx_byte_q;
  assign rsp_o.tx_valid          = tx_vld_q;
  assign rsp_o.samples_available = avail_q;
  assign rsp_o.overflowed        = ovf_out_q;
  assign rsp_o.reg_write_strobe  = strobe_q;
  assign rsp_o.reg_write_index   = widx_q;
  assign rsp_o.reg_write_value   = wval_q;
  assign rsp_o.transfer_end      = tend_q;

endmodule

### rtl/i2crf_checker.sv
// port-level checker for the register file top level, with its bind
module i2crf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  tx_byte_i,
  input logic        tx_valid_i,
  input logic [11:0] samples_i,
  input logic        overflowed_i,
  input logic        strobe_i,
  input logic [4:0]  widx_i,
  input logic [15:0] wval_i,
  input logic        tend_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_acc)
    else $error("request accepted in back-to-back cycles");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({tx_byte_i, tx_valid_i, samples_i, overflowed_i, strobe_i, widx_i, wval_i,
               tend_i}))
    else $error("stalled result changed");

  a_strobe_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !strobe_i |-> widx_i == 5'd0 && wval_i == 16'h0000)
    else $error("write index or value without strobe");

  a_tx_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(tx_valid_i && strobe_i) && (tx_valid_i || tx_byte_i == 8'h00)
      && !(tend_i && (tx_valid_i || strobe_i)))
    else $error("result carries more than one kind of event");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(samples_i) <= i2crf_pkg::RING_DEPTH)
    else $error("sample count beyond ring depth");

endmodule

bind i2c_register_file_with_sample_fifo i2crf_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .tx_byte_i    (rsp_o.tx_byte),
  .tx_valid_i   (rsp_o.tx_valid),
  .samples_i    (rsp_o.samples_available),
  .overflowed_i (rsp_o.overflowed),
  .strobe_i     (rsp_o.reg_write_strobe),
  .widx_i       (rsp_o.reg_write_index),
  .wval_i       (rsp_o.reg_write_value),
  .tend_i       (rsp_o.transfer_end)
);
